@@ rtl/core/tmsgd_pkg.sv @@
// ----------------------------------------------------------------------------
// tmsgd_pkg
// Shared types and constants of the 2-2-1 network trainer: action and
// register codes, sequencer states, shared multiplier widths and control.
// ----------------------------------------------------------------------------
`default_nettype none

package tmsgd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SIG_DEPTH_DEF = 256;
    localparam int LR_FRAC       = 16;

    localparam int IO_W = 17;
    localparam logic [IO_W-1:0] IO_MAX = 17'h1FFFF;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    // shared multiplier: A operand is split in two halves, one per cycle
    localparam int AW = 48;
    localparam int AH = 24;
    localparam int BW = 34;
    localparam int PW = AW + BW;

    // hidden step term, clamped to +/-2^40
    localparam int TW       = 42;
    localparam int STEP_EXP = 40;

    // actions
    localparam logic [1:0] ACT_INIT    = 2'd0;
    localparam logic [1:0] ACT_TRAIN   = 2'd1;
    localparam logic [1:0] ACT_PREDICT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LR     = 2'd0;
    localparam logic [1:0] CFG_SIMPLE = 2'd1;
    localparam logic [1:0] CFG_SEED   = 2'd2;

    localparam logic [23:0] LR_RESET   = 24'd6554;
    localparam logic [31:0] SEED_RESET = 32'd1337;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LCG,
        S_H0A, S_H0B, S_H1A, S_H1B,
        S_OA,  S_OB,
        S_SQ,  S_G,
        S_W4,  S_W5,
        S_T0,  S_D0, S_TD0, S_X00, S_X01,
        S_T1,  S_D1, S_TD1, S_X10, S_X11,
        S_OUT
    } t_state;

    typedef struct packed {
        logic en;
        logic hi;
        logic accum;
    } t_mul_ctl;

    // seed offset of each weight
    function automatic logic [31:0] lcg_off(input logic [2:0] idx);
        logic [31:0] r;
        unique case (idx)
            3'd1:    r = 32'd2;
            3'd2:    r = 32'd1;
            3'd3:    r = 32'd3;
            3'd5:    r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tmsgd_mul.sv @@
// ----------------------------------------------------------------------------
// tmsgd_mul
// Shared signed multiply-accumulate unit. A product is built from the low
// half of A first, then the high half shifted and added.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsgd_mul (
    input  wire                                  i_clk,
    input  tmsgd_pkg::t_mul_ctl                  i_ctl,
    input  wire logic signed [tmsgd_pkg::AW-1:0] i_a,
    input  wire logic signed [tmsgd_pkg::BW-1:0] i_b,
    output logic signed      [tmsgd_pkg::PW-1:0] o_acc
);
    import tmsgd_pkg::*;

    logic signed [AH:0]      m_a;
    logic signed [AH+BW:0]   prod;
    logic signed [PW-1:0]    addend;
    logic signed [PW-1:0]    base;
    logic signed [PW-1:0]    r_acc;

    always_comb begin
        if (i_ctl.hi) begin
            m_a = $signed({i_a[AW-1], i_a[AW-1:AH]});
        end else begin
            m_a = $signed({1'b0, i_a[AH-1:0]});
        end
        prod   = m_a * i_b;
        addend = i_ctl.hi ? (PW'(prod) <<< AH) : PW'(prod);
        base   = (i_ctl.hi || i_ctl.accum) ? r_acc : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= base + addend;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

@@ rtl/core/tmsgd_sigmoid.sv @@
// ----------------------------------------------------------------------------
// tmsgd_sigmoid
// Sigmoid by nearest-entry table lookup over [-8, 8). The table is built
// at elaboration with integer arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsgd_sigmoid #(
    parameter int FRAC_BITS = tmsgd_pkg::FRAC_BITS_DEF,
    parameter int DEPTH     = tmsgd_pkg::SIG_DEPTH_DEF
) (
    input  wire logic signed [tmsgd_pkg::PW-1:0] i_x,
    output logic             [FRAC_BITS:0]       o_y
);
    import tmsgd_pkg::*;

    localparam int HW  = FRAC_BITS + 1;
    localparam int IXW = $clog2(DEPTH);
    localparam int HALF = DEPTH / 2;
    localparam logic [63:0] H_STEP = (64'd16 << 32) / DEPTH;

    typedef logic [HW-1:0] t_sig_tab [DEPTH];

    // shift-subtract quotient, elaboration only
    function automatic logic [63:0] cdiv(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_sig_tab build_tab();
        t_sig_tab    tab;
        logic [63:0] one;
        logic [63:0] h;
        logic [63:0] num;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] s;
        logic [63:0] onef;
        int          half;
        one  = 64'd1 << 32;
        h    = H_STEP;
        num  = 64'd1 << (32 + FRAC_BITS);
        onef = 64'd1 << FRAC_BITS;
        half = HALF;
        term = one;
        e    = one;
        p    = one;
        for (int i = 0; i < DEPTH; i++) begin
            tab[i] = '0;
        end
        // exp(-16/D), ten Taylor terms in Q32
        for (int n = 1; n <= 10; n++) begin
            term = cdiv((term * h) >> 32, 64'(n));
            if ((n & 1) == 1) begin
                e = e - term;
            end else begin
                e = e + term;
            end
        end
        for (int m = 0; m <= half; m++) begin
            den = one + p;
            s   = cdiv(num + (den >> 1), den);
            if (half + m < DEPTH) begin
                tab[half + m] = HW'(s);
            end
            tab[half - m] = HW'(onef - s);
            p = (p * e + (64'd1 << 31)) >> 32;
        end
        tab[half] = HW'(onef >> 1);
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = build_tab();

    localparam logic signed [PW-1:0] X_LIM = PW'(64'sd32 <<< FRAC_BITS);
    localparam logic signed [63:0]   V_OFS =
        64'sd16 * (64'sd1 <<< FRAC_BITS) * 64'(HALF) + (64'sd8 <<< FRAC_BITS);
    localparam logic signed [63:0]   DEP   = 64'(DEPTH);
    localparam logic signed [63:0]   V_TOP = 64'(DEPTH - 1);

    logic signed [PW-1:0] xc;
    logic signed [63:0]   v;
    logic signed [63:0]   vi;
    logic [IXW-1:0]       idx;

    always_comb begin
        if (i_x > X_LIM) begin
            xc = X_LIM;
        end else if (i_x < -X_LIM) begin
            xc = -X_LIM;
        end else begin
            xc = i_x;
        end
        v  = 64'(xc) * DEP + V_OFS;
        vi = v >>> (FRAC_BITS + 4);
        if (v < 0) begin
            idx = '0;
        end else if (vi > V_TOP) begin
            idx = IXW'(DEPTH - 1);
        end else begin
            idx = vi[IXW-1:0];
        end
        o_y = SIG_TAB[idx];
    end

endmodule

`default_nettype wire

@@ rtl/core/tiny_mlp_sgd_trainer_core.sv @@
// ----------------------------------------------------------------------------
// tiny_mlp_sgd_trainer_core
// 2-2-1 sigmoid network with one SGD step per training item.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries action and three Q16
// samples; output channel (o_out_valid / i_out_stall) returns one result per
// item: prediction, squared error and the saturation flag.
// Configuration writes (learning rate, simple mode, seed) go over i_cfg_valid
// / o_cfg_ready (always high); the user must write only while idle (unchecked).
// All multiplications run through one shared multiply-accumulate unit. Each
// product runs as low half, high half, then write back. Products per item:
// predict 7, init 12 LCG steps, train 20, or 16 in simple mode. One item is
// processed at a time; the input side stalls until the core returns to idle.
// A finished result sits in the output register; the core can accept the
// next item while it waits there, and holds its own finish until the
// receiver takes it.
// Reset clears the weights to zero and loads the default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module tiny_mlp_sgd_trainer_core #(
    parameter int FRAC_BITS           = tmsgd_pkg::FRAC_BITS_DEF,
    parameter int SIGMOID_TABLE_DEPTH = tmsgd_pkg::SIG_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_action,
    input  wire  [16:0] i_sample_recent,
    input  wire  [16:0] i_sample_older,
    input  wire  [16:0] i_target_value,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [16:0] o_prediction,
    output logic [16:0] o_squared_error,
    output logic        o_saturated,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    import tmsgd_pkg::*;

    localparam int HW  = FRAC_BITS + 1;
    localparam int DW  = ((FRAC_BITS > IO_W) ? FRAC_BITS : IO_W) + 2;
    localparam int GW  = DW + 10;
    localparam int PW1 = PW + 1;

    localparam logic [HW-1:0]         ONEF    = HW'(1) << FRAC_BITS;
    localparam logic signed [PW-1:0]  STEP_HI = PW'(1) <<< STEP_EXP;
    localparam logic signed [PW-1:0]  SQ_MAX  = PW'(IO_MAX);
    localparam logic signed [PW1-1:0] W_MAX   = (PW1'(1) <<< 31) - PW1'(1);
    localparam logic signed [PW1-1:0] W_MIN   = -(PW1'(1) <<< 31);

    t_state r_state, n_state;
    logic [1:0] r_ph;
    logic       is_op, op_done, in_acc;

    // configuration
    logic [23:0] r_lr;
    logic        r_simple;
    logic [31:0] r_seed_cfg;

    // item state
    logic [1:0]              r_act;
    logic [IO_W-1:0]         r_x0, r_x1, r_tgt;
    logic [HW-1:0]           r_h0, r_h1, r_pred, r_dsig;
    logic signed [DW-1:0]    r_diff;
    logic signed [GW-1:0]    r_g;
    logic signed [TW-1:0]    r_t;
    logic [IO_W-1:0]         r_sq;
    logic                    r_sat;
    logic [31:0]             r_seed;
    logic [2:0]              r_widx;
    logic                    r_lstep;
    logic signed [31:0]      r_w [6];

    logic                    r_out_valid;
    logic [IO_W-1:0]         r_out_pred, r_out_sq;
    logic                    r_out_sat;

    // datapath
    t_mul_ctl                mul_ctl;
    logic                    mul_accum;
    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [PW-1:0]    mul_acc;
    logic signed [PW-1:0]    acc_sh, acc_lr;
    logic [2:0]              widx;
    logic signed [31:0]      w_rd;
    logic [HW-1:0]           sig_y;
    logic signed [PW-1:0]    step_v;
    logic                    step_sat;
    logic                    is_x;
    logic signed [PW-1:0]    sub_rhs;
    logic signed [PW1-1:0]   wdiff;
    logic signed [31:0]      wnew;
    logic                    wsat;
    logic [31:0]             lcg_s;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign is_op   = (r_state != S_IDLE) && (r_state != S_OUT);
    assign op_done = is_op && (r_ph == 2'd2);

    tmsgd_mul u_mul (
        .i_clk (i_clk),
        .i_ctl (mul_ctl),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_acc (mul_acc)
    );

    assign acc_sh = mul_acc >>> FRAC_BITS;
    assign acc_lr = mul_acc >>> LR_FRAC;

    tmsgd_sigmoid #(
        .FRAC_BITS (FRAC_BITS),
        .DEPTH     (SIGMOID_TABLE_DEPTH)
    ) u_sig (
        .i_x (acc_sh),
        .o_y (sig_y)
    );

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) begin
                n_state = (i_action == ACT_INIT) ? S_LCG : S_H0A;
            end
            S_LCG:  if (op_done && r_lstep && (r_widx == 3'd5)) n_state = S_OUT;
            S_H0A:  if (op_done) n_state = S_H0B;
            S_H0B:  if (op_done) n_state = S_H1A;
            S_H1A:  if (op_done) n_state = S_H1B;
            S_H1B:  if (op_done) n_state = S_OA;
            S_OA:   if (op_done) n_state = S_OB;
            S_OB:   if (op_done) n_state = S_SQ;
            S_SQ:   if (op_done) n_state = (r_act == ACT_TRAIN) ? S_G : S_OUT;
            S_G:    if (op_done) n_state = S_W4;
            S_W4:   if (op_done) n_state = S_W5;
            S_W5:   if (op_done) n_state = S_T0;
            S_T0:   if (op_done) n_state = r_simple ? S_X00 : S_D0;
            S_D0:   if (op_done) n_state = S_TD0;
            S_TD0:  if (op_done) n_state = S_X00;
            S_X00:  if (op_done) n_state = S_X01;
            S_X01:  if (op_done) n_state = S_T1;
            S_T1:   if (op_done) n_state = r_simple ? S_X10 : S_D1;
            S_D1:   if (op_done) n_state = S_TD1;
            S_TD1:  if (op_done) n_state = S_X10;
            S_X10:  if (op_done) n_state = S_X11;
            S_X11:  if (op_done) n_state = S_OUT;
            S_OUT:  if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer: operand selection ----------------
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_accum = 1'b0;
        widx      = 3'd0;
        unique case (r_state)
            S_LCG: begin
                mul_a = AW'({1'b0, r_seed});
                mul_b = BW'({1'b0, LCG_MUL});
                widx  = r_widx;
            end
            S_H0A: begin widx = 3'd0; mul_a = AW'(w_rd); mul_b = BW'({1'b0, r_x0}); end
            S_H0B: begin
                widx = 3'd1; mul_a = AW'(w_rd); mul_b = BW'({1'b0, r_x1}); mul_accum = 1'b1;
            end
            S_H1A: begin widx = 3'd2; mul_a = AW'(w_rd); mul_b = BW'({1'b0, r_x0}); end
            S_H1B: begin
                widx = 3'd3; mul_a = AW'(w_rd); mul_b = BW'({1'b0, r_x1}); mul_accum = 1'b1;
            end
            S_OA:  begin widx = 3'd4; mul_a = AW'(w_rd); mul_b = BW'({1'b0, r_h0}); end
            S_OB:  begin
                widx = 3'd5; mul_a = AW'(w_rd); mul_b = BW'({1'b0, r_h1}); mul_accum = 1'b1;
            end
            S_SQ:  begin mul_a = AW'(r_diff); mul_b = BW'(r_diff); end
            S_G:   begin mul_a = AW'({1'b0, r_lr}); mul_b = BW'(r_diff) <<< 1; end
            S_W4:  begin widx = 3'd4; mul_a = AW'(r_g); mul_b = BW'({1'b0, r_h0}); end
            S_W5:  begin widx = 3'd5; mul_a = AW'(r_g); mul_b = BW'({1'b0, r_h1}); end
            S_T0:  begin widx = 3'd4; mul_a = AW'(r_g); mul_b = BW'(w_rd); end
            S_D0:  begin mul_a = AW'({1'b0, r_h0}); mul_b = BW'({1'b0, ONEF - r_h0}); end
            S_TD0: begin mul_a = AW'(r_t); mul_b = BW'({1'b0, r_dsig}); end
            S_X00: begin widx = 3'd0; mul_a = AW'(r_t); mul_b = BW'({1'b0, r_x0}); end
            S_X01: begin widx = 3'd1; mul_a = AW'(r_t); mul_b = BW'({1'b0, r_x1}); end
            S_T1:  begin widx = 3'd5; mul_a = AW'(r_g); mul_b = BW'(w_rd); end
            S_D1:  begin mul_a = AW'({1'b0, r_h1}); mul_b = BW'({1'b0, ONEF - r_h1}); end
            S_TD1: begin mul_a = AW'(r_t); mul_b = BW'({1'b0, r_dsig}); end
            S_X10: begin widx = 3'd2; mul_a = AW'(r_t); mul_b = BW'({1'b0, r_x0}); end
            S_X11: begin widx = 3'd3; mul_a = AW'(r_t); mul_b = BW'({1'b0, r_x1}); end
            default: ;
        endcase
        mul_ctl.en    = is_op && (r_ph != 2'd2);
        mul_ctl.hi    = (r_ph == 2'd1);
        mul_ctl.accum = mul_accum;
    end

    assign w_rd = r_w[widx];

    // ---------------- clamps and weight update ----------------
    always_comb begin
        if (acc_sh > STEP_HI) begin
            step_v = STEP_HI; step_sat = 1'b1;
        end else if (acc_sh < -STEP_HI) begin
            step_v = -STEP_HI; step_sat = 1'b1;
        end else begin
            step_v = acc_sh; step_sat = 1'b0;
        end
        is_x    = (r_state == S_X00) || (r_state == S_X01) ||
                  (r_state == S_X10) || (r_state == S_X11);
        sub_rhs = is_x ? step_v : acc_sh;
        wdiff   = PW1'(w_rd) - PW1'(sub_rhs);
        if (wdiff > W_MAX) begin
            wnew = 32'(W_MAX); wsat = 1'b1;
        end else if (wdiff < W_MIN) begin
            wnew = 32'(W_MIN); wsat = 1'b1;
        end else begin
            wnew = 32'(wdiff); wsat = 1'b0;
        end
        lcg_s = mul_acc[31:0] + LCG_ADD;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 2'd0;
        end else begin
            r_state <= n_state;
            if (is_op && (r_ph != 2'd2)) begin
                r_ph <= r_ph + 2'd1;
            end else begin
                r_ph <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr       <= LR_RESET;
            r_simple   <= 1'b0;
            r_seed_cfg <= SEED_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LR:     r_lr       <= i_cfg_data[23:0];
                CFG_SIMPLE: r_simple   <= i_cfg_data[0];
                CFG_SEED:   r_seed_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // weights reset to zero; one write port at the current index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_w[k] <= '0;
            end
        end else if (op_done) begin
            if (r_state == S_LCG && r_lstep) begin
                r_w[widx] <= 32'(lcg_s >> (32 - FRAC_BITS));
            end else if (r_state == S_W4 || r_state == S_W5 || is_x) begin
                r_w[widx] <= wnew;
            end
        end
    end

    // ---------------- item registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act   <= i_action;
            r_x0    <= i_sample_recent;
            r_x1    <= i_sample_older;
            r_tgt   <= i_target_value;
            r_sat   <= 1'b0;
            r_seed  <= r_seed_cfg;
            r_widx  <= 3'd0;
            r_lstep <= 1'b0;
        end else if (op_done) begin
            unique case (r_state)
                S_LCG: begin
                    if (!r_lstep) begin
                        r_seed  <= lcg_s;
                        r_lstep <= 1'b1;
                    end else begin
                        r_seed  <= r_seed_cfg + lcg_off(r_widx + 3'd1);
                        r_widx  <= r_widx + 3'd1;
                        r_lstep <= 1'b0;
                    end
                end
                S_H0B: r_h0 <= sig_y;
                S_H1B: r_h1 <= sig_y;
                S_OB: begin
                    r_pred <= sig_y;
                    r_diff <= $signed(DW'(sig_y)) - $signed(DW'(r_tgt));
                end
                S_SQ: r_sq <= (acc_sh > SQ_MAX) ? IO_MAX : acc_sh[IO_W-1:0];
                S_G:  r_g  <= GW'(acc_lr);
                S_W4, S_W5, S_X00, S_X01, S_X10, S_X11: begin
                    r_sat <= r_sat | wsat | (is_x & step_sat);
                end
                S_T0, S_T1, S_TD0, S_TD1: begin
                    r_t   <= step_v[TW-1:0];
                    r_sat <= r_sat | step_sat;
                end
                S_D0, S_D1: r_dsig <= acc_sh[HW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
            if (r_act == ACT_INIT) begin
                r_out_pred <= '0;
                r_out_sq   <= '0;
                r_out_sat  <= 1'b0;
            end else begin
                r_out_pred <= IO_W'(r_pred);
                r_out_sq   <= r_sq;
                r_out_sat  <= r_sat && (r_act == ACT_TRAIN);
            end
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_prediction    = r_out_pred;
    assign o_squared_error = r_out_sq;
    assign o_saturated     = r_out_sat;

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("core not busy after input transfer");

    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT) |-> !mul_ctl.en)
        else $error("multiplier active outside an operation");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result appeared without finishing an item");

    a_ph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph != 2'd0) |-> is_op)
        else $error("phase counter running while idle");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2-2-1 network trainer. A bit-exact predictor
// in a scoreboard class tracks weights and registers, queues the expected
// result of every accepted input transfer and checks each output transfer
// in order. Stimulus is a directed opener, then random phases of init,
// train, predict and spare-action items under varying register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import tmsgd_pkg::*;

typedef struct {
    logic [16:0] pred;
    logic [16:0] sq_err;
    logic        sat;
} t_train_result;

class trainer_scoreboard;
    t_train_result    pending_q[$];
    longint           wt[6];
    logic [23:0]      lr;
    logic             simple;
    logic [31:0]      seed;
    longint           sig_lut[256];
    bit               clamp_hit;
    int               errors;
    int               n_checked;
    int               n_sat;

    function new();
        logic [63:0] one, h, num, den, term, e, p;
        int half;
        one  = 64'd1 << 32;
        h    = (64'd16 << 32) / 256;
        num  = 64'd1 << 48;
        half = 128;
        term = one; e = one; p = one;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * h) >> 32) / n;
            if (n & 1) e = e - term;
            else e = e + term;
        end
        for (int m = 0; m <= half; m++) begin
            den = one + p;
            if (half + m < 256) sig_lut[half + m] = (num + den / 2) / den;
            sig_lut[half - m] = 65536 - longint'((num + den / 2) / den);
            p = (p * e + (64'd1 << 31)) >> 32;
        end
        sig_lut[half] = 32768;
        lr = LR_RESET; simple = 1'b0; seed = SEED_RESET;
        foreach (wt[k]) wt[k] = 0;
        errors = 0; n_checked = 0; n_sat = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            CFG_LR:     lr = data[23:0];
            CFG_SIMPLE: simple = data[0];
            CFG_SEED:   seed = data;
            default: ;
        endcase
    endfunction

    function longint sigmoid(longint x);
        longint v, idx;
        if (x > (longint'(32) << 16)) x = longint'(32) << 16;
        if (x < -(longint'(32) << 16)) x = -(longint'(32) << 16);
        v = x * 256 + 128 * (longint'(16) << 16) + (longint'(8) << 16);
        idx = (v < 0) ? 0 : (v >>> 20);
        if (idx > 255) idx = 255;
        return sig_lut[idx];
    endfunction

    function longint clamp_term(longint v);
        longint lim;
        lim = longint'(1) << 40;
        if (v > lim) begin clamp_hit = 1; return lim; end
        if (v < -lim) begin clamp_hit = 1; return -lim; end
        return v;
    endfunction

    function longint sat_weight(longint v);
        if (v > 64'sd2147483647) begin clamp_hit = 1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin clamp_hit = 1; return -64'sd2147483648; end
        return v;
    endfunction

    function logic [31:0] lcg_seed_off(int k);
        case (k)
            1: return 32'd2;
            2: return 32'd1;
            3: return 32'd3;
            5: return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

    // accepted input transfer: compute expected result, update weights
    function void note_item(logic [1:0] act, logic [16:0] xr, logic [16:0] xo,
                            logic [16:0] tg);
        t_train_result r;
        longint x[2], hid[2], pred, diff, sqv, g, t, dsig, st;
        logic [31:0] s;
        r = '{default: '0};
        if (act == ACT_INIT) begin
            for (int k = 0; k < 6; k++) begin
                s = seed + lcg_seed_off(k);
                s = LCG_MUL * s + LCG_ADD;
                s = LCG_MUL * s + LCG_ADD;
                wt[k] = s >> 16;
            end
            pending_q.push_back(r);
            return;
        end
        x[0] = xr; x[1] = xo;
        clamp_hit = 0;
        for (int i = 0; i < 2; i++)
            hid[i] = sigmoid((wt[2*i] * x[0] + wt[2*i+1] * x[1]) >>> 16);
        pred = sigmoid((wt[4] * hid[0] + wt[5] * hid[1]) >>> 16);
        diff = pred - longint'(tg);
        sqv = (diff * diff) >>> 16;
        if (sqv > 131071) sqv = 131071;
        if (act == ACT_TRAIN) begin
            g = (longint'(lr) * (2 * diff)) >>> 16;
            for (int i = 0; i < 2; i++)
                wt[4+i] = sat_weight(wt[4+i] - ((g * hid[i]) >>> 16));
            // hidden step deliberately uses the freshly updated output weights
            for (int i = 0; i < 2; i++) begin
                t = clamp_term((g * wt[4+i]) >>> 16);
                if (!simple) begin
                    dsig = (hid[i] * (65536 - hid[i])) >>> 16;
                    t = clamp_term((t * dsig) >>> 16);
                end
                for (int j = 0; j < 2; j++) begin
                    st = clamp_term((t * x[j]) >>> 16);
                    wt[2*i+j] = sat_weight(wt[2*i+j] - st);
                end
            end
            r.sat = clamp_hit;
        end
        r.pred = pred[16:0];
        r.sq_err = sqv[16:0];
        pending_q.push_back(r);
    endfunction

    function void check_result(logic [16:0] pred, logic [16:0] sq_err, logic sat);
        t_train_result e;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result pred=%0d sq=%0d sat=%0d",
                     $time, pred, sq_err, sat);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        n_checked++;
        if (sat) n_sat++;
        if (pred !== e.pred) begin
            $display("%0t: prediction exp %0d got %0d", $time, e.pred, pred);
            errors++;
        end
        if (sq_err !== e.sq_err) begin
            $display("%0t: squared_error exp %0d got %0d", $time, e.sq_err, sq_err);
            errors++;
        end
        if (sat !== e.sat) begin
            $display("%0t: saturated exp %0d got %0d", $time, e.sat, sat);
            errors++;
        end
    endfunction
endclass

    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  action = ACT_PREDICT;
    logic [16:0] smp_recent = '0;
    logic [16:0] smp_older = '0;
    logic [16:0] target = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    logic [16:0] o_prediction;
    logic [16:0] o_squared_error;
    logic        o_saturated;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  cfg_index = CFG_LR;
    logic [31:0] cfg_data = '0;

    trainer_scoreboard sb = new();
    int  cycles = 0;
    int  stall_left = 0;
    bit  no_idle = 0;
    int  n_items = 0;

    tiny_mlp_sgd_trainer_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall),
        .i_action(action), .i_sample_recent(smp_recent),
        .i_sample_older(smp_older), .i_target_value(target),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_prediction(o_prediction), .o_squared_error(o_squared_error),
        .o_saturated(o_saturated),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tiny_mlp_sgd_trainer_core verification failed");
            $finish;
        end
    end

    // monitors: values sampled here are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_valid && o_cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (in_valid && !o_in_stall) begin
                sb.note_item(action, smp_recent, smp_older, target);
                n_items++;
            end
            if (o_out_valid && !out_stall)
                sb.check_result(o_prediction, o_squared_error, o_saturated);
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 70);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else begin
            stall_left <= pick_gap();
            out_stall <= 1'b0;
        end
    end

    task automatic send(logic [1:0] a, logic [16:0] xr, logic [16:0] xo,
                        logic [16:0] tg);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        action     <= a;
        smp_recent <= xr;
        smp_older  <= xo;
        target     <= tg;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [16:0] rand_q16();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 17'd0;
        if (r < 16) return 17'd65536;
        if (r < 24) return 17'($urandom_range(65537, 131071));
        return 17'($urandom_range(0, 65536));
    endfunction

    initial begin
        logic [1:0] a;
        int r, n_phase;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero weights, defaults, extremes, every action
        send(ACT_PREDICT, 17'd0, 17'd0, 17'd0);
        send(ACT_TRAIN, 17'd65536, 17'd65536, 17'd65536);
        send(ACT_INIT, 17'd0, 17'd0, 17'd0);
        send(ACT_PREDICT, 17'd65536, 17'd0, 17'd0);
        send(ACT_TRAIN, 17'd0, 17'd65536, 17'd0);
        send(ACT_TRAIN, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        send(ACT_SPARE, 17'd32768, 17'd32768, 17'd0);
        send(ACT_TRAIN, 17'd0, 17'd0, 17'h1FFFF);
        write_cfg(CFG_LR, 32'hFFFFFFFF);
        write_cfg(CFG_SIMPLE, 32'd1);
        write_cfg(CFG_SEED, 32'hFFFFFFFF);
        send(ACT_INIT, 17'd0, 17'd0, 17'd0);
        repeat (6) send(ACT_TRAIN, 17'h1FFFF, 17'h1FFFF, 17'd0);
        send(ACT_PREDICT, 17'h1FFFF, 17'd0, 17'h1FFFF);
        write_cfg(CFG_SIMPLE, 32'd0);
        repeat (4) send(ACT_TRAIN, 17'h1FFFF, 17'd65536, 17'h1FFFF);
        write_cfg(CFG_LR, 32'd1);
        write_cfg(CFG_SEED, 32'd0);
        send(ACT_INIT, 17'd0, 17'd0, 17'd0);
        send(ACT_TRAIN, 17'd65536, 17'd65536, 17'd0);

        n_phase = 0;
        while (n_items < 1120) begin
            // pause: all outstanding results in before reprogramming
            r = $urandom_range(0, 9);
            write_cfg(CFG_LR, r < 2 ? 32'd1 : r < 4 ? 32'hFFFFFF :
                      r < 7 ? $urandom_range(1, 65536) : $urandom_range(1, 24'hFFFFFF));
            write_cfg(CFG_SIMPLE, $urandom_range(0, 1));
            write_cfg(CFG_SEED, $urandom);
            no_idle = (n_phase % 3 == 2);
            send(ACT_INIT, rand_q16(), rand_q16(), rand_q16());
            repeat (110) begin
                r = $urandom_range(0, 99);
                a = r < 3 ? ACT_INIT : r < 75 ? ACT_TRAIN : r < 96 ? ACT_PREDICT : ACT_SPARE;
                send(a, rand_q16(), rand_q16(), rand_q16());
            end
            n_phase++;
        end
        no_idle = 0;
        drain();
        repeat (80) @(posedge i_clk);
        $display("covered %0d items in %0d random phases, %0d results checked, %0d saturated",
                 n_items, n_phase, sb.n_checked, sb.n_sat);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tiny_mlp_sgd_trainer_core verification clean");
        else
            $display("tiny_mlp_sgd_trainer_core verification failed");
        $finish;
    end
endmodule

`default_nettype wire
